// ----- src/mlfq_pkg.sv -----
// Shared constants and request, result and job record types of the multilevel feedback queue scheduler.
package mlfq_pkg;

    localparam int MAX_JOBS   = 16;
    localparam int SLOT_W     = 4;
    localparam int NUM_LEVELS = 4;
    localparam int LVL_W      = 2;
    localparam int TIME_W     = 32;
    localparam int CNT_W      = 5;

    localparam logic [2:0] CFG_LEVELS   = 3'd0;
    localparam logic [2:0] CFG_QUANTUM0 = 3'd1;
    localparam logic [2:0] CFG_QUANTUM1 = 3'd2;
    localparam logic [2:0] CFG_QUANTUM2 = 3'd3;
    localparam logic [2:0] CFG_QUANTUM3 = 3'd4;

    localparam logic REQ_REGISTER = 1'b0;
    localparam logic REQ_STEP     = 1'b1;

    typedef struct packed {
        logic              req_type;
        logic [SLOT_W-1:0] slot;
        logic [15:0]       arrival_time;
        logic [15:0]       burst_time;
    } t_in;

    typedef struct packed {
        logic              idle_tick;
        logic [SLOT_W-1:0] ran_slot;
        logic [LVL_W-1:0]  ran_level;
        logic [15:0]       run_length;
        logic [31:0]       time_after;
        logic              finished;
        logic [31:0]       turnaround;
        logic [31:0]       waiting;
        logic              all_done;
    } t_out;

    typedef struct packed {
        logic [15:0] arrival;
        logic [15:0] burst;
        logic [15:0] remaining;
    } t_rec;

endpackage

// ----- src/multilevel_feedback_queue_scheduler_core.sv -----
// Multilevel feedback queue scheduler core with job record and level FIFO memories.
//
//   channel   signals                               direction
//   request   i_in_valid / o_in_stall / i_in_data   in
//   result    o_out_valid / i_out_stall / o_out_data out
//   config    i_cfg_we / i_cfg_index / i_cfg_data   in
//
// A register request passes through S_REG and S_OUT before the next acceptance.
// A step request runs the admission scan, which reads one job record per cycle,
// then S_PICK; a run adds S_FRD and S_RUN, a finished run also S_TAT and S_WT.
// One request is worked on at a time; a new one is taken while the result register
// still holds an earlier result, and a stalled result holds the next one back.
// Reset is synchronous and clears flags, counts, FIFO pointers and time; the
// memories are not cleared.
module multilevel_feedback_queue_scheduler_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  mlfq_pkg::t_in       i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output mlfq_pkg::t_out      o_out_data,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_REG  = 4'd1;
    localparam logic [3:0] S_SCAN = 4'd2;
    localparam logic [3:0] S_PICK = 4'd3;
    localparam logic [3:0] S_FRD  = 4'd4;
    localparam logic [3:0] S_RUN  = 4'd5;
    localparam logic [3:0] S_TAT  = 4'd6;
    localparam logic [3:0] S_WT   = 4'd7;
    localparam logic [3:0] S_OUT  = 4'd8;

    localparam int FIFO_AW = mlfq_pkg::LVL_W + mlfq_pkg::SLOT_W;

    mlfq_pkg::t_rec                   rec_mem [mlfq_pkg::MAX_JOBS];
    logic [mlfq_pkg::SLOT_W-1:0]      fifo_mem [mlfq_pkg::NUM_LEVELS*mlfq_pkg::MAX_JOBS];

    logic [3:0]                        r_state;
    mlfq_pkg::t_in                     r_req;
    logic [2:0]                        r_levels_cfg;
    logic [15:0]                       r_quantum [mlfq_pkg::NUM_LEVELS];
    logic [mlfq_pkg::MAX_JOBS-1:0]     r_registered;
    logic [mlfq_pkg::MAX_JOBS-1:0]     r_admitted;
    logic [mlfq_pkg::SLOT_W-1:0]       r_head [mlfq_pkg::NUM_LEVELS];
    logic [mlfq_pkg::CNT_W-1:0]        r_count [mlfq_pkg::NUM_LEVELS];
    logic [mlfq_pkg::TIME_W-1:0]       r_time;
    logic [mlfq_pkg::CNT_W-1:0]        r_reg_count;
    logic [mlfq_pkg::CNT_W-1:0]        r_done_count;
    logic [mlfq_pkg::CNT_W-1:0]        r_idx;
    logic [mlfq_pkg::SLOT_W-1:0]       r_prev;
    logic                              r_pend;
    logic [mlfq_pkg::LVL_W-1:0]        r_lvl;
    logic [mlfq_pkg::SLOT_W-1:0]       r_job;
    mlfq_pkg::t_rec                    r_rec_rd;
    logic [mlfq_pkg::SLOT_W-1:0]       r_fifo_rd;
    logic [31:0]                       r_tat;
    mlfq_pkg::t_out                    r_res;
    logic                              r_ovalid;
    mlfq_pkg::t_out                    r_odata;

    logic [mlfq_pkg::SLOT_W-1:0]       rec_raddr;
    logic                              rec_we;
    logic [mlfq_pkg::SLOT_W-1:0]       rec_waddr;
    mlfq_pkg::t_rec                    rec_wdata;
    logic [FIFO_AW-1:0]                fifo_raddr;
    logic                              fifo_we;
    logic [FIFO_AW-1:0]                fifo_waddr;
    logic [mlfq_pkg::SLOT_W-1:0]       fifo_wdata;
    logic                              scan_hit;
    logic                              pick_found;
    logic [mlfq_pkg::LVL_W-1:0]        pick_lvl;
    logic [2:0]                        levels;
    logic [15:0]                       quantum;
    logic                              run_more;
    logic [15:0]                       run_len;
    logic [mlfq_pkg::TIME_W:0]         time_sum;
    logic [mlfq_pkg::TIME_W-1:0]       time_sat;
    logic [mlfq_pkg::LVL_W-1:0]        push_lvl;
    logic                              out_load;
    mlfq_pkg::t_out                    res_final;

    assign levels = (r_levels_cfg == 3'd0) ? 3'd1 :
                    (r_levels_cfg > 3'(mlfq_pkg::NUM_LEVELS)) ?
                    3'(mlfq_pkg::NUM_LEVELS) : r_levels_cfg;
    assign quantum  = (r_quantum[r_lvl] == 16'd0) ? 16'd1 : r_quantum[r_lvl];
    assign run_more = r_rec_rd.remaining > quantum;
    assign run_len  = run_more ? quantum : r_rec_rd.remaining;
    assign push_lvl = ({1'b0, r_lvl} + 3'd1 < levels) ? r_lvl + 2'd1 : r_lvl;
    assign time_sum = {1'b0, r_time}
                    + ((r_state == S_RUN) ? (mlfq_pkg::TIME_W+1)'(run_len)
                                          : (mlfq_pkg::TIME_W+1)'(1));
    assign time_sat = time_sum[mlfq_pkg::TIME_W] ? '1 : time_sum[mlfq_pkg::TIME_W-1:0];
    assign scan_hit = r_pend && r_registered[r_prev] && !r_admitted[r_prev]
                   && (mlfq_pkg::TIME_W'(r_rec_rd.arrival) <= r_time)
                   && !r_count[0][mlfq_pkg::CNT_W-1];
    assign out_load = (r_state == S_OUT) && (!r_ovalid || !i_out_stall);

    always_comb begin
        res_final          = r_res;
        res_final.all_done = (r_done_count == r_reg_count);
    end

    always_comb begin
        pick_found = 1'b0;
        pick_lvl   = '0;
        for (int l = mlfq_pkg::NUM_LEVELS - 1; l >= 0; l--) begin
            if (r_count[l] != '0) begin
                pick_found = 1'b1;
                pick_lvl   = mlfq_pkg::LVL_W'(l);
            end
        end
    end

    always_comb begin
        rec_raddr  = r_idx[mlfq_pkg::SLOT_W-1:0];
        rec_we     = 1'b0;
        rec_waddr  = r_req.slot;
        rec_wdata  = r_rec_rd;
        fifo_raddr = {pick_lvl, r_head[pick_lvl]};
        fifo_we    = 1'b0;
        fifo_waddr = {{mlfq_pkg::LVL_W{1'b0}},
                      r_head[0] + r_count[0][mlfq_pkg::SLOT_W-1:0]};
        fifo_wdata = r_prev;
        unique case (r_state)
            S_REG: begin
                rec_we    = !r_registered[r_req.slot];
                rec_wdata.arrival   = r_req.arrival_time;
                rec_wdata.burst     = (r_req.burst_time == 16'd0) ? 16'd1 : r_req.burst_time;
                rec_wdata.remaining = rec_wdata.burst;
            end
            S_SCAN: begin
                fifo_we = scan_hit;
            end
            S_FRD: begin
                rec_raddr = r_fifo_rd;
            end
            S_RUN: begin
                rec_raddr = r_job;
                rec_we    = 1'b1;
                rec_waddr = r_job;
                rec_wdata.remaining = run_more ? r_rec_rd.remaining - quantum : 16'd0;
                fifo_we    = run_more && !r_count[push_lvl][mlfq_pkg::CNT_W-1];
                fifo_waddr = {push_lvl,
                              r_head[push_lvl] + r_count[push_lvl][mlfq_pkg::SLOT_W-1:0]};
                fifo_wdata = r_job;
            end
            S_TAT, S_WT: begin
                rec_raddr = r_job;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (rec_we) begin
            rec_mem[rec_waddr] <= rec_wdata;
        end
        r_rec_rd <= rec_mem[rec_raddr];
        if (fifo_we) begin
            fifo_mem[fifo_waddr] <= fifo_wdata;
        end
        r_fifo_rd <= fifo_mem[fifo_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_levels_cfg <= 3'd4;
            r_quantum[0] <= 16'd1;
            r_quantum[1] <= 16'd2;
            r_quantum[2] <= 16'd4;
            r_quantum[3] <= 16'd8;
            r_registered <= '0;
            r_admitted   <= '0;
            for (int l = 0; l < mlfq_pkg::NUM_LEVELS; l++) begin
                r_head[l]  <= '0;
                r_count[l] <= '0;
            end
            r_time       <= '0;
            r_reg_count  <= '0;
            r_done_count <= '0;
            r_pend       <= 1'b0;
            r_ovalid     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == mlfq_pkg::CFG_LEVELS) begin
                    r_levels_cfg <= i_cfg_data[2:0];
                end else if (i_cfg_index >= mlfq_pkg::CFG_QUANTUM0
                             && i_cfg_index <= mlfq_pkg::CFG_QUANTUM3) begin
                    r_quantum[2'(i_cfg_index - mlfq_pkg::CFG_QUANTUM0)] <= i_cfg_data;
                end
            end

            if (out_load) begin
                r_ovalid <= 1'b1;
                r_odata  <= res_final;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_req <= i_in_data;
                        r_res <= '0;
                        r_idx <= '0;
                        r_pend <= 1'b0;
                        r_state <= (i_in_data.req_type == mlfq_pkg::REQ_STEP) ? S_SCAN : S_REG;
                    end
                end
                S_REG: begin
                    if (!r_registered[r_req.slot]) begin
                        r_registered[r_req.slot] <= 1'b1;
                        r_admitted[r_req.slot]   <= 1'b0;
                        r_reg_count <= r_reg_count + 1'b1;
                    end
                    r_res.ran_slot   <= r_req.slot;
                    r_res.time_after <= r_time;
                    r_state <= S_OUT;
                end
                S_SCAN: begin
                    if (scan_hit) begin
                        r_admitted[r_prev] <= 1'b1;
                        r_count[0] <= r_count[0] + 1'b1;
                    end
                    if (!r_idx[mlfq_pkg::CNT_W-1]) begin
                        r_prev <= r_idx[mlfq_pkg::SLOT_W-1:0];
                        r_pend <= 1'b1;
                        r_idx  <= r_idx + 1'b1;
                    end else begin
                        r_pend  <= 1'b0;
                        r_state <= S_PICK;
                    end
                end
                S_PICK: begin
                    if (!pick_found) begin
                        r_time <= time_sat;
                        r_res.idle_tick  <= 1'b1;
                        r_res.time_after <= time_sat;
                        r_state <= S_OUT;
                    end else begin
                        r_lvl <= pick_lvl;
                        r_head[pick_lvl]  <= r_head[pick_lvl] + 1'b1;
                        r_count[pick_lvl] <= r_count[pick_lvl] - 1'b1;
                        r_state <= S_FRD;
                    end
                end
                S_FRD: begin
                    r_job   <= r_fifo_rd;
                    r_state <= S_RUN;
                end
                S_RUN: begin
                    r_time <= time_sat;
                    r_res.ran_slot   <= r_job;
                    r_res.ran_level  <= r_lvl;
                    r_res.run_length <= run_len;
                    r_res.time_after <= time_sat;
                    if (run_more) begin
                        if (!r_count[push_lvl][mlfq_pkg::CNT_W-1]) begin
                            r_count[push_lvl] <= r_count[push_lvl] + 1'b1;
                        end
                        r_state <= S_OUT;
                    end else begin
                        r_res.finished <= 1'b1;
                        r_done_count   <= r_done_count + 1'b1;
                        r_state <= S_TAT;
                    end
                end
                S_TAT: begin
                    r_tat <= (r_time >= 32'(r_rec_rd.arrival)) ?
                             r_time - 32'(r_rec_rd.arrival) : 32'd0;
                    r_state <= S_WT;
                end
                S_WT: begin
                    r_res.turnaround <= r_tat;
                    r_res.waiting    <= (r_tat >= 32'(r_rec_rd.burst)) ?
                                        r_tat - 32'(r_rec_rd.burst) : 32'd0;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_odata;

endmodule
